[sv/rrc_pkg.sv]
// Shared constants for the RNS rescale coefficient core.
package rrc_pkg;

   localparam int WORD_WIDTH_DEF = 64;
   localparam int RES_WIDTH      = 61;
   localparam int LAST_WIDTH     = 63;
   localparam int RATIO_WIDTH    = 64;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int REQ_DATA_WIDTH = 128;
   localparam int RSP_DATA_WIDTH = 64;
   localparam int PIPE_DEPTH     = 17;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_PRIME      = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_RATIO_LOW  = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_RATIO_HIGH = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_INV_LAST   = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_HALF_OFF   = 3'd4;

endpackage

[sv/rns_rescale_coefficient_core.sv]
// RNS rescale core: divides one coefficient by the last prime with rounding, one word per cycle.
// Accepts one word per clock unless the output stalls, and returns the results in order. The depth
// is set by five chained word multiplies (Barrett quotient, quotient times q, product by the
// inverse, the four-product ratio multiply, and quotient times q), each built from registered
// half-width partial products, plus the subtract and carry stages between them. Any rsp_tready
// low with a result waiting holds the whole pipeline; no word is lost or repeated.
// req_tdata: residue [60:0], last_residue [123:61]. rsp_tdata: scaled_residue [60:0].
// Registers are written through csr_* at indices 0..4; write them only while idle.
module rns_rescale_coefficient_core #(
   parameter int WORD_WIDTH = rrc_pkg::WORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rrc_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [rrc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rrc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,   // residue, last_residue
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rrc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata    // scaled_residue
);

   localparam int W  = WORD_WIDTH;
   localparam int ND = rrc_pkg::PIPE_DEPTH;

   logic [rrc_pkg::RES_WIDTH-1:0]   prime_ff;
   logic [rrc_pkg::RATIO_WIDTH-1:0] ratio_low_ff;
   logic [rrc_pkg::RATIO_WIDTH-1:0] ratio_high_ff;
   logic [rrc_pkg::RES_WIDTH-1:0]   inv_prime_ff;
   logic [rrc_pkg::RES_WIDTH-1:0]   half_off_ff;

   logic [W-1:0] q_w, r0_w, r1_w, inv_w, half_w;

   logic          adv;
   logic [ND-1:0] vld_ff;

   logic [W-1:0] res_pipe_ff  [0:6];
   logic [W-1:0] last_pipe_ff [0:4];
   logic [W-1:0] z0_pipe_ff   [0:5];

   logic [2*W-1:0] pa, pb, pc, m1, m2, m3, m4, pe;

   logic [W-1:0] tx_ff, tx_in, ty_ff, ty_in, ta_ff, ta_in;
   logic [W-1:0] k1_t1_ff, k1_t3_ff, k1_m3lo_ff, k1_m3hi_ff, k1_m4lo_ff;
   logic [W-1:0] k1_t1_in, k1_t3_in;
   logic [W-1:0] k2_t1_ff, k2_t1_in;
   logic [W-1:0] out_ff, out_in;
   logic [W-1:0] x_diff, y_diff, z_diff, f_diff, k2_s, k2_carry;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff      <= rrc_pkg::RES_WIDTH'(2);
         ratio_low_ff  <= '0;
         ratio_high_ff <= '0;
         inv_prime_ff  <= '0;
         half_off_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            rrc_pkg::REG_PRIME: begin
               prime_ff <= csr_wdata[rrc_pkg::RES_WIDTH-1:0];
            end
            rrc_pkg::REG_RATIO_LOW: begin
               ratio_low_ff <= csr_wdata;
            end
            rrc_pkg::REG_RATIO_HIGH: begin
               ratio_high_ff <= csr_wdata;
            end
            rrc_pkg::REG_INV_LAST: begin
               inv_prime_ff <= csr_wdata[rrc_pkg::RES_WIDTH-1:0];
            end
            rrc_pkg::REG_HALF_OFF: begin
               half_off_ff <= csr_wdata[rrc_pkg::RES_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign q_w    = W'(prime_ff);
   assign r0_w   = W'(ratio_low_ff);
   assign r1_w   = W'(ratio_high_ff);
   assign inv_w  = W'(inv_prime_ff);
   assign half_w = W'(half_off_ff);

   // Pipeline control: advance when the output slot is free or being taken
   assign adv        = rsp_tready | ~vld_ff[ND-1];
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[ND-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ND-2:0], req_tvalid};
      end
   end

   // Side delay lines
   always_ff @(posedge clock) begin
      if (adv) begin
         res_pipe_ff[0]  <= W'(req_tdata[rrc_pkg::RES_WIDTH-1:0]);
         last_pipe_ff[0] <= W'(req_tdata[rrc_pkg::RES_WIDTH+rrc_pkg::LAST_WIDTH-1:
                                         rrc_pkg::RES_WIDTH]);
         for (int i = 1; i < 7; i++) begin
            res_pipe_ff[i] <= res_pipe_ff[i-1];
         end
         for (int i = 1; i < 5; i++) begin
            last_pipe_ff[i] <= last_pipe_ff[i-1];
         end
         z0_pipe_ff[0] <= pc[W-1:0];
         for (int i = 1; i < 6; i++) begin
            z0_pipe_ff[i] <= z0_pipe_ff[i-1];
         end
      end
   end

   // Barrett quotient of last_residue, then quotient times q
   rrc_wide_mul #(.WORD_WIDTH(W)) u_mul_a (
      .clock(clock), .enable(adv), .op_a(last_pipe_ff[0]), .op_b(r1_w), .product(pa));
   rrc_wide_mul #(.WORD_WIDTH(W)) u_mul_b (
      .clock(clock), .enable(adv), .op_a(pa[2*W-1:W]), .op_b(q_w), .product(pb));

   always_comb begin
      x_diff = last_pipe_ff[4] - pb[W-1:0];
      tx_in  = (x_diff >= q_w) ? x_diff - q_w : x_diff;
      y_diff = tx_ff - half_w;
      ty_in  = (tx_ff < half_w) ? y_diff + q_w : y_diff;
      z_diff = res_pipe_ff[6] - ty_ff;
      ta_in  = (res_pipe_ff[6] < ty_ff) ? z_diff + q_w : z_diff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tx_ff <= tx_in;
         ty_ff <= ty_in;
         ta_ff <= ta_in;
      end
   end

   // Product by the inverse of the last prime
   rrc_wide_mul #(.WORD_WIDTH(W)) u_mul_c (
      .clock(clock), .enable(adv), .op_a(ta_ff), .op_b(inv_w), .product(pc));

   // Two-word ratio products
   rrc_wide_mul #(.WORD_WIDTH(W)) u_mul_d1 (
      .clock(clock), .enable(adv), .op_a(pc[W-1:0]), .op_b(r0_w), .product(m1));
   rrc_wide_mul #(.WORD_WIDTH(W)) u_mul_d2 (
      .clock(clock), .enable(adv), .op_a(pc[W-1:0]), .op_b(r1_w), .product(m2));
   rrc_wide_mul #(.WORD_WIDTH(W)) u_mul_d3 (
      .clock(clock), .enable(adv), .op_a(pc[2*W-1:W]), .op_b(r0_w), .product(m3));
   rrc_wide_mul #(.WORD_WIDTH(W)) u_mul_d4 (
      .clock(clock), .enable(adv), .op_a(pc[2*W-1:W]), .op_b(r1_w), .product(m4));

   always_comb begin
      k1_t1_in = m2[W-1:0] + m1[2*W-1:W];
      k1_t3_in = m2[2*W-1:W] + W'(k1_t1_in < m2[W-1:0]);
      k2_s     = k1_t1_ff + k1_m3lo_ff;
      k2_carry = k1_m3hi_ff + W'(k2_s < k1_t1_ff);
      k2_t1_in = k1_m4lo_ff + k1_t3_ff + k2_carry;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k1_t1_ff   <= k1_t1_in;
         k1_t3_ff   <= k1_t3_in;
         k1_m3lo_ff <= m3[W-1:0];
         k1_m3hi_ff <= m3[2*W-1:W];
         k1_m4lo_ff <= m4[W-1:0];
         k2_t1_ff   <= k2_t1_in;
      end
   end

   // Quotient times q and final correction
   rrc_wide_mul #(.WORD_WIDTH(W)) u_mul_e (
      .clock(clock), .enable(adv), .op_a(k2_t1_ff), .op_b(q_w), .product(pe));

   always_comb begin
      f_diff = z0_pipe_ff[5] - pe[W-1:0];
      out_in = (f_diff >= q_w) ? f_diff - q_w : f_diff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tdata = rrc_pkg::RSP_DATA_WIDTH'(rrc_pkg::RES_WIDTH'(out_ff));

endmodule

[sv/rrc_wide_mul.sv]
// Two-stage word by word multiplier built from four half-width partial products.
module rrc_wide_mul #(
   parameter int WORD_WIDTH = rrc_pkg::WORD_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [WORD_WIDTH-1:0]     op_a,
   input  logic [WORD_WIDTH-1:0]     op_b,
   output logic [2*WORD_WIDTH-1:0]   product
);

   localparam int LW = (WORD_WIDTH + 1) / 2;
   localparam int HW = WORD_WIDTH - LW;

   logic [2*LW-1:0]        p00_ff;
   logic [LW+HW-1:0]       p01_ff;
   logic [LW+HW-1:0]       p10_ff;
   logic [2*HW-1:0]        p11_ff;
   logic [2*WORD_WIDTH-1:0] product_ff;
   logic [2*WORD_WIDTH-1:0] product_in;

   always_ff @(posedge clock) begin
      if (enable) begin
         p00_ff     <= (2*LW)'(op_a[LW-1:0]) * (2*LW)'(op_b[LW-1:0]);
         p01_ff     <= (LW+HW)'(op_a[LW-1:0]) * (LW+HW)'(op_b[WORD_WIDTH-1:LW]);
         p10_ff     <= (LW+HW)'(op_a[WORD_WIDTH-1:LW]) * (LW+HW)'(op_b[LW-1:0]);
         p11_ff     <= (2*HW)'(op_a[WORD_WIDTH-1:LW]) * (2*HW)'(op_b[WORD_WIDTH-1:LW]);
         product_ff <= product_in;
      end
   end

   always_comb begin
      product_in = {p11_ff, p00_ff}
                 + (((2*WORD_WIDTH)'(p01_ff) + (2*WORD_WIDTH)'(p10_ff)) << LW);
   end

   assign product = product_ff;

endmodule
